// File: hdl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Shared codes, limits and reset values of the LIN slave responder.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int ANSWER_COUNT_DEF = 8;
    localparam int ANSWER_BYTES_DEF = 9;
    localparam int FRAME_MAX        = 64;

    localparam int CFG_DW = 16;
    localparam int CFG_IW = 2;

    localparam logic [CFG_IW-1:0] CFG_RX_ENABLE    = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_FRAME_LIMIT  = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_IDLE_TIMEOUT = 2'd2;

    localparam logic [6:0]  RST_FRAME_LIMIT  = 7'd16;
    localparam logic [15:0] RST_IDLE_TIMEOUT = 16'd2000;

    localparam logic [2:0] CMD_BREAK = 3'd0;
    localparam logic [2:0] CMD_RX    = 3'd1;
    localparam logic [2:0] CMD_TICK  = 3'd2;
    localparam logic [2:0] CMD_TXRDY = 3'd3;
    localparam logic [2:0] CMD_HDR   = 3'd4;
    localparam logic [2:0] CMD_BYTE  = 3'd5;

    localparam logic [1:0] KIND_TX    = 2'd0;
    localparam logic [1:0] KIND_CAP   = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;
    localparam logic [1:0] KIND_REJ   = 2'd3;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_BREAK = 2'd1;
    localparam logic [1:0] MODE_DATA  = 2'd2;

    localparam logic [1:0] CHK_CLASSIC  = 2'd1;
    localparam logic [1:0] CHK_ENHANCED = 2'd2;

    localparam logic [7:0] SYNC_BYTE = 8'h55;

endpackage

// File: hdl/lin_slave_responder_top.sv
// ----------------------------------------------------------------------------
// lin_slave_responder_top
// LIN capture and slave answer engine with checksum rebuild.
// ----------------------------------------------------------------------------
// One word is taken at a time. Break, tick, table writes and ignored commands
// that give no result pass through the done state; a word that gives results
// sends its result words one after another, holding while the output stalls.
// A received byte that completes sync and protected id walks the answer
// headers one entry per cycle, up to ANSWER_COUNT entries, and on a match
// reads the first answer byte from the answer store. A transmitter-ready word
// that sends a byte reads it from the store before its result. One that ends
// an answer runs the post-send update over the store's single write port, one
// write per answer byte plus one for the checksum byte when it is rebuilt.
module lin_slave_responder_top
    import lsr_pkg::*;
#(
    parameter int ANSWER_COUNT = ANSWER_COUNT_DEF,
    parameter int ANSWER_BYTES = ANSWER_BYTES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [lsr_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [lsr_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_cmd,
    input  logic [7:0]                i_rx_byte,
    input  logic [2:0]                i_entry_index,
    input  logic [7:0]                i_entry_id,
    input  logic [3:0]                i_entry_length,
    input  logic [1:0]                i_check_mode,
    input  logic [3:0]                i_byte_position,
    input  logic [7:0]                i_data_value,
    input  logic [7:0]                i_increment_value,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [1:0]                o_kind,
    output logic [7:0]                o_byte_value,
    output logic [6:0]                o_position,
    output logic                      o_frame_with_break,
    output logic                      o_last
);

    localparam int DEPTH = ANSWER_COUNT * ANSWER_BYTES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = (ANSWER_COUNT > 1) ? $clog2(ANSWER_COUNT) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DONE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_RDWAIT = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;
    localparam logic [2:0] S_SWR    = 3'd5;
    localparam logic [2:0] S_SCHK   = 3'd6;

    function automatic logic [AW-1:0] f_addr(logic [IW-1:0] e, logic [3:0] p);
        return AW'(AW'(e) * AW'(ANSWER_BYTES) + AW'(p));
    endfunction

    logic [2:0]  r_state;
    logic        r_rx_en;
    logic [6:0]  r_frame_limit;
    logic [15:0] r_idle_timeout;

    logic [1:0]  r_mode;
    logic [6:0]  r_cnt;
    logic [6:0]  r_size;
    logic [7:0]  r_first;
    logic [7:0]  r_prev;
    logic [15:0] r_ticks;

    logic          r_tx_active;
    logic [IW-1:0] r_tx_entry;
    logic [3:0]    r_tx_pos;
    logic [3:0]    r_tx_len;

    logic [7:0] r_hid   [ANSWER_COUNT];
    logic [3:0] r_hlen  [ANSWER_COUNT];
    logic [1:0] r_hmode [ANSWER_COUNT];

    logic [IW-1:0] r_sidx;
    logic [7:0]    r_pid;
    logic [IW-1:0] r_se;
    logic [3:0]    r_k;
    logic [3:0]    r_slen;
    logic          r_schk;
    logic [7:0]    r_sum;
    logic [7:0]    r_inc;

    logic       r_pend_cap, r_pend_tx, r_pend_cls, r_pend_rej;
    logic [7:0] r_cap_val;
    logic [6:0] r_cap_pos;
    logic [7:0] r_txo_val;
    logic [3:0] r_txo_pos;
    logic [6:0] r_cls_pos;
    logic       r_cls_brk;

    logic       r_ovalid;
    logic [1:0] r_okind;
    logic [7:0] r_oval;
    logic [6:0] r_opos;
    logic       r_obrk;
    logic       r_olast;

    logic          in_acc;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    logic [6:0]  lim;
    logic [6:0]  cnt_d;
    logic [1:0]  mode_e;
    logic [6:0]  cnt0;
    logic [6:0]  cnt1;
    logic [6:0]  size_e;
    logic [7:0]  first_e;
    logic [15:0] ticks_n;
    logic [7:0]  nd;
    logic [8:0]  sum_a;
    logic [7:0]  sum_n;
    logic        out_free;
    logic [3:0]  k1;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_ovalid || i_out_ready;

    always_comb begin
        if (r_frame_limit == 7'd0) begin
            lim = 7'd1;
        end else if (32'(r_frame_limit) > FRAME_MAX) begin
            lim = 7'(FRAME_MAX);
        end else begin
            lim = r_frame_limit;
        end
        cnt_d   = r_cnt - 7'((r_cnt != 7'd0) && (r_prev == 8'd0));
        mode_e  = (r_mode == MODE_IDLE) ? MODE_DATA : r_mode;
        cnt0    = (r_mode == MODE_IDLE) ? 7'd0 : r_cnt;
        cnt1    = cnt0 + 7'd1;
        size_e  = (r_mode == MODE_IDLE) ? lim : r_size;
        first_e = (cnt0 == 7'd0) ? i_rx_byte : r_first;
        ticks_n = r_ticks + 16'(r_ticks != 16'hFFFF);
        nd      = ram_rdata[15:8] + ram_rdata[7:0];
        sum_a   = {1'b0, r_sum} + {1'b0, nd};
        sum_n   = (sum_a >= 9'h100) ? 8'(sum_a - 9'h0FF) : sum_a[7:0];
        k1      = r_k + 4'd1;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = f_addr(r_se, r_k);
        ram_wdata = {nd, ram_rdata[7:0]};
        ram_raddr = f_addr(r_tx_entry, (r_tx_pos < r_tx_len) ? r_tx_pos : 4'd0);
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_cmd == CMD_BYTE && 32'(i_entry_index) < ANSWER_COUNT
                    && 32'(i_byte_position) < ANSWER_BYTES) begin
                    ram_we    = 1'b1;
                    ram_waddr = f_addr(IW'(i_entry_index), i_byte_position);
                    ram_wdata = {i_data_value, i_increment_value};
                end
            end
            S_SEARCH: ram_raddr = f_addr(r_sidx, 4'd0);
            S_SWR: begin
                ram_we    = 1'b1;
                ram_raddr = f_addr(r_se, k1);
            end
            S_SCHK: begin
                ram_we    = 1'b1;
                ram_waddr = f_addr(r_se, r_slen - 4'd1);
                ram_wdata = {~r_sum, r_inc};
            end
            default: ;
        endcase
    end

    lsr_answer_ram #(
        .DEPTH(DEPTH),
        .AW   (AW),
        .DW   (16)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_en        <= 1'b0;
            r_frame_limit  <= RST_FRAME_LIMIT;
            r_idle_timeout <= RST_IDLE_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RX_ENABLE:    r_rx_en        <= i_cfg_data[0];
                CFG_FRAME_LIMIT:  r_frame_limit  <= i_cfg_data[6:0];
                CFG_IDLE_TIMEOUT: r_idle_timeout <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_cnt       <= 7'd0;
            r_size      <= RST_FRAME_LIMIT;
            r_first     <= 8'd0;
            r_prev      <= 8'd0;
            r_ticks     <= 16'd0;
            r_tx_active <= 1'b0;
            r_tx_entry  <= '0;
            r_tx_pos    <= 4'd0;
            r_tx_len    <= 4'd0;
            r_pend_cap  <= 1'b0;
            r_pend_tx   <= 1'b0;
            r_pend_cls  <= 1'b0;
            r_pend_rej  <= 1'b0;
            r_ovalid    <= 1'b0;
            for (int i = 0; i < ANSWER_COUNT; i++) begin
                r_hid[i]   <= 8'd0;
                r_hlen[i]  <= 4'd0;
                r_hmode[i] <= 2'd0;
            end
        end else begin
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_DONE;
                        unique case (i_cmd)
                            CMD_BREAK: begin
                                if (r_mode == MODE_IDLE || cnt_d != 7'd0) begin
                                    if (r_mode != MODE_IDLE) begin
                                        r_pend_cls <= 1'b1;
                                        r_cls_pos  <= cnt_d;
                                        r_cls_brk  <= (r_mode == MODE_BREAK);
                                        r_state    <= S_EMIT;
                                    end
                                    r_ticks <= 16'd0;
                                    if (r_rx_en) begin
                                        r_size <= lim;
                                        r_cnt  <= 7'd0;
                                        r_mode <= MODE_BREAK;
                                    end else begin
                                        r_cnt  <= cnt_d;
                                        r_mode <= MODE_IDLE;
                                    end
                                end else begin
                                    r_cnt   <= 7'd0;
                                    r_mode  <= MODE_BREAK;
                                    r_ticks <= 16'd0;
                                end
                            end
                            CMD_RX: begin
                                if (r_mode != MODE_IDLE || r_rx_en) begin
                                    r_first    <= first_e;
                                    r_prev     <= i_rx_byte;
                                    r_pend_cap <= 1'b1;
                                    r_cap_val  <= i_rx_byte;
                                    r_cap_pos  <= cnt0;
                                    r_cnt      <= cnt1;
                                    r_size     <= size_e;
                                    r_ticks    <= 16'd0;
                                    if (cnt1 >= size_e) begin
                                        r_mode     <= MODE_IDLE;
                                        r_pend_cls <= 1'b1;
                                        r_cls_pos  <= cnt1;
                                        r_cls_brk  <= (mode_e == MODE_BREAK);
                                    end else begin
                                        r_mode <= mode_e;
                                    end
                                    if (mode_e == MODE_BREAK && cnt1 == 7'd2
                                        && first_e == SYNC_BYTE && !r_tx_active) begin
                                        r_sidx  <= '0;
                                        r_pid   <= i_rx_byte;
                                        r_state <= S_SEARCH;
                                    end else begin
                                        r_state <= S_EMIT;
                                    end
                                end
                            end
                            CMD_TICK: begin
                                if (r_mode != MODE_IDLE) begin
                                    r_ticks <= ticks_n;
                                    if (ticks_n >= r_idle_timeout) begin
                                        r_pend_cls <= 1'b1;
                                        r_cls_pos  <= r_cnt;
                                        r_cls_brk  <= (r_mode == MODE_BREAK);
                                        r_mode     <= MODE_IDLE;
                                        r_ticks    <= 16'd0;
                                        r_state    <= S_EMIT;
                                    end
                                end
                            end
                            CMD_TXRDY: begin
                                if (r_tx_active) begin
                                    if (r_tx_pos >= r_tx_len) begin
                                        r_tx_active <= 1'b0;
                                        r_se        <= r_tx_entry;
                                        r_k         <= 4'd0;
                                        r_slen      <= r_hlen[r_tx_entry];
                                        r_schk      <= (r_hmode[r_tx_entry] == CHK_CLASSIC)
                                                    || (r_hmode[r_tx_entry] == CHK_ENHANCED);
                                        r_sum       <= (r_hmode[r_tx_entry] == CHK_ENHANCED)
                                                    ? r_hid[r_tx_entry] : 8'd0;
                                        if (r_hlen[r_tx_entry] != 4'd0) begin
                                            r_state <= S_SWR;
                                        end
                                    end else begin
                                        r_txo_pos <= r_tx_pos;
                                        r_tx_pos  <= r_tx_pos + 4'd1;
                                        r_state   <= S_RDWAIT;
                                    end
                                end
                            end
                            CMD_HDR: begin
                                if (32'(i_entry_index) >= ANSWER_COUNT
                                    || 32'(i_entry_length) > ANSWER_BYTES) begin
                                    r_pend_rej <= 1'b1;
                                    r_state    <= S_EMIT;
                                end else begin
                                    r_hid[IW'(i_entry_index)]   <= i_entry_id;
                                    r_hlen[IW'(i_entry_index)]  <= i_entry_length;
                                    r_hmode[IW'(i_entry_index)] <= i_check_mode;
                                end
                            end
                            CMD_BYTE: begin
                                if (32'(i_entry_index) >= ANSWER_COUNT
                                    || 32'(i_byte_position) >= ANSWER_BYTES) begin
                                    r_pend_rej <= 1'b1;
                                    r_state    <= S_EMIT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DONE: r_state <= S_IDLE;
                S_SEARCH: begin
                    if (r_hid[r_sidx] == r_pid && r_hlen[r_sidx] != 4'd0) begin
                        r_tx_active <= 1'b1;
                        r_tx_entry  <= r_sidx;
                        r_tx_len    <= r_hlen[r_sidx];
                        r_tx_pos    <= 4'd1;
                        r_txo_pos   <= 4'd0;
                        r_state     <= S_RDWAIT;
                    end else if (32'(r_sidx) == ANSWER_COUNT - 1) begin
                        r_state <= S_EMIT;
                    end else begin
                        r_sidx <= r_sidx + IW'(1);
                    end
                end
                S_RDWAIT: begin
                    r_pend_tx <= 1'b1;
                    r_txo_val <= ram_rdata[15:8];
                    r_state   <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovalid <= r_pend_cap || r_pend_tx || r_pend_cls || r_pend_rej;
                        r_obrk   <= 1'b0;
                        r_oval   <= 8'd0;
                        r_opos   <= 7'd0;
                        if (r_pend_cap) begin
                            r_pend_cap <= 1'b0;
                            r_okind    <= KIND_CAP;
                            r_oval     <= r_cap_val;
                            r_opos     <= r_cap_pos;
                            r_olast    <= !(r_pend_tx || r_pend_cls);
                            if (!(r_pend_tx || r_pend_cls)) r_state <= S_IDLE;
                        end else if (r_pend_tx) begin
                            r_pend_tx <= 1'b0;
                            r_okind   <= KIND_TX;
                            r_oval    <= r_txo_val;
                            r_opos    <= 7'(r_txo_pos);
                            r_olast   <= !r_pend_cls;
                            if (!r_pend_cls) r_state <= S_IDLE;
                        end else if (r_pend_cls) begin
                            r_pend_cls <= 1'b0;
                            r_okind    <= KIND_CLOSE;
                            r_opos     <= r_cls_pos;
                            r_obrk     <= r_cls_brk;
                            r_olast    <= 1'b1;
                            r_state    <= S_IDLE;
                        end else begin
                            r_pend_rej <= 1'b0;
                            r_okind    <= KIND_REJ;
                            r_olast    <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                S_SWR: begin
                    r_inc <= ram_rdata[7:0];
                    r_k   <= k1;
                    if (k1 < r_slen) begin
                        r_sum <= sum_n;
                    end else begin
                        r_state <= r_schk ? S_SCHK : S_IDLE;
                    end
                end
                S_SCHK: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_ovalid;
    assign o_kind             = r_okind;
    assign o_byte_value       = r_oval;
    assign o_position         = r_opos;
    assign o_frame_with_break = r_obrk;
    assign o_last             = r_olast;

endmodule

// File: hdl/lsr_answer_ram.sv
// ----------------------------------------------------------------------------
// lsr_answer_ram
// Answer byte store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lsr_answer_ram #(
    parameter int DEPTH = 72,
    parameter int AW    = 7,
    parameter int DW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hdl/lsr_checker.sv
// ----------------------------------------------------------------------------
// lsr_checker
// Port-level checks of the LIN slave responder, bound to the top level.
// ----------------------------------------------------------------------------
module lsr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [1:0]                o_kind,
    input logic [7:0]                o_byte_value,
    input logic [6:0]                o_position,
    input logic                      o_frame_with_break,
    input logic                      o_last
);
    import lsr_pkg::*;

    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken on back-to-back cycles");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_kind)
            && $stable(o_byte_value) && $stable(o_position)))
        else $error("stalled result word changed");

    a_reject_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_REJ) |->
            (o_last && o_byte_value == 8'd0 && o_position == 7'd0))
        else $error("reject word malformed");

    a_break_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind != KIND_CLOSE) |-> !o_frame_with_break)
        else $error("break flag outside close word");

    a_close_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind == KIND_CLOSE) |-> o_last)
        else $error("close word not last");

endmodule

bind lin_slave_responder_top lsr_checker u_lsr_checker (.*);
